// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/prrl_pkg.sv =====
// ----------------------------------------------------------------------------
// prrl_pkg
// types and constants shared by the rate limiter modules
// ----------------------------------------------------------------------------
`default_nettype none

package prrl_pkg;

    localparam int TIME_WIDTH     = 32;
    localparam int QUOTA_WIDTH    = 32;
    localparam int CFG_INDEX_W    = 2;
    localparam int CAPACITY_RESET = 1000;
    localparam int INTERVAL_RESET = 1000;

    localparam logic ENABLE_RESET = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd2;

    localparam logic CMD_CONSUME = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FILL_RUN,
        S_APPLY,
        S_FULL_START,
        S_FULL_RUN,
        S_DES_START,
        S_DES_RUN,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

    typedef enum logic [1:0] {
        SEL_FILL,
        SEL_FULL,
        SEL_DES
    } md_sel_t;

    typedef struct packed {
        logic    capture;
        logic    set_disabled;
        logic    set_bypass;
        logic    take_fill;
        logic    apply;
        logic    take_full;
        logic    take_des;
        logic    load_out;
        logic    md_start;
        md_sel_t md_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic enable;
        logic fill_bypass;
        logic cap_zero;
        logic md_done;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== src/proportional_refill_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// proportional_refill_rate_limiter
// token bucket limiter with proportional refill and wait-time reporting
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in_valid/in_stall    command, now_ms, amount, desired_quota
//  out      out_valid/out_stall  quota, wait_full_ms, wait_desired_ms,
//                                full_at_ms, desired_at_ms
//
//  one transaction at a time; W = max(TIME_WIDTH, QUOTA_WIDTH)
//  the serial multiply-divide unit takes W multiply and 2*W divide steps and
//  runs up to three times per transaction (refill, full wait, desired wait)
//  disabled skips all passes; full bucket or zero interval skips the refill pass, zero capacity the waits
//  reset restores capacity 1000, interval 1000, full bucket; cfg_ready stays high
//  a held result does not block the next transaction until its own result is due
// ----------------------------------------------------------------------------
`default_nettype none

module proportional_refill_rate_limiter #(
    parameter int TIME_WIDTH  = prrl_pkg::TIME_WIDTH,
    parameter int QUOTA_WIDTH = prrl_pkg::QUOTA_WIDTH,
    parameter int W           = (TIME_WIDTH > QUOTA_WIDTH) ? TIME_WIDTH : QUOTA_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [prrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [W-1:0]                     cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             command,
    input  wire logic [TIME_WIDTH-1:0]            now_ms,
    input  wire logic [QUOTA_WIDTH-1:0]           amount,
    input  wire logic [QUOTA_WIDTH-1:0]           desired_quota,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [QUOTA_WIDTH-1:0]                quota,
    output logic [TIME_WIDTH-1:0]                 wait_full_ms,
    output logic [TIME_WIDTH-1:0]                 wait_desired_ms,
    output logic [TIME_WIDTH-1:0]                 full_at_ms,
    output logic [TIME_WIDTH-1:0]                 desired_at_ms
);

    prrl_pkg::ctrl_cmd_t    cmd;
    prrl_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    prrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    prrl_datapath #(
        .TW(TIME_WIDTH),
        .QW(QUOTA_WIDTH),
        .W (W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .now_ms         (now_ms),
        .amount         (amount),
        .desired_quota  (desired_quota),
        .cmd            (cmd),
        .status         (status),
        .quota          (quota),
        .wait_full_ms   (wait_full_ms),
        .wait_desired_ms(wait_desired_ms),
        .full_at_ms     (full_at_ms),
        .desired_at_ms  (desired_at_ms)
    );

endmodule

`default_nettype wire

// ===== src/prrl_muldiv.sv =====
// ----------------------------------------------------------------------------
// prrl_muldiv
// serial floor(a*b/d): shift-add multiply then restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module prrl_muldiv #(
    parameter int W = prrl_pkg::TIME_WIDTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    input  wire logic [W-1:0]   d,
    output logic                done,
    output logic [2*W-1:0]      q
);

    localparam int PW    = 2 * W;
    localparam int CNT_W = $clog2(PW);

    prrl_pkg::md_phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [W-1:0]        mcand_reg, mcand_next;
    logic [W-1:0]        div_reg, div_next;
    logic [W-1:0]        rem_reg, rem_next;

    logic [W:0] mul_sum;
    logic [W:0] rem_shift;
    logic [W:0] rem_diff;
    logic       take;
    logic       mul_last;
    logic       div_last;

    assign mul_sum   = {1'b0, prod_reg[PW-1:W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign take      = (rem_shift >= {1'b0, div_reg});
    assign mul_last  = (cnt_reg == CNT_W'(W - 1));
    assign div_last  = (cnt_reg == CNT_W'(PW - 1));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            prrl_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    phase_next = prrl_pkg::MD_MUL;
                end
            end
            prrl_pkg::MD_MUL:
            begin
                if (mul_last)
                begin
                    phase_next = prrl_pkg::MD_DIV;
                end
            end
            prrl_pkg::MD_DIV:
            begin
                if (div_last)
                begin
                    phase_next = prrl_pkg::MD_IDLE;
                end
            end
            default:
            begin
                phase_next = prrl_pkg::MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        unique case (phase_reg)
            prrl_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    prod_next  = {{W{1'b0}}, b};
                    mcand_next = a;
                    div_next   = d;
                    rem_next   = '0;
                end
            end
            prrl_pkg::MD_MUL:
            begin
                prod_next = {mul_sum, prod_reg[W-1:1]};
                cnt_next  = mul_last ? '0 : cnt_reg + 1'b1;
            end
            prrl_pkg::MD_DIV:
            begin
                rem_next  = take ? rem_diff[W-1:0] : rem_shift[W-1:0];
                prod_next = {prod_reg[PW-2:0], take};
                cnt_next  = cnt_reg + 1'b1;
                done_next = div_last;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= prrl_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign q    = prod_reg;

endmodule

`default_nettype wire

// ===== src/prrl_datapath.sv =====
// ----------------------------------------------------------------------------
// prrl_datapath
// configuration, bucket state, operand selection and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module prrl_datapath #(
    parameter int TW = prrl_pkg::TIME_WIDTH,
    parameter int QW = prrl_pkg::QUOTA_WIDTH,
    parameter int W  = (TW > QW) ? TW : QW
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [prrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [W-1:0]                     cfg_data,
    input  wire logic                             command,
    input  wire logic [TW-1:0]                    now_ms,
    input  wire logic [QW-1:0]                    amount,
    input  wire logic [QW-1:0]                    desired_quota,
    input  wire prrl_pkg::ctrl_cmd_t              cmd,
    output prrl_pkg::ctrl_status_t                status,
    output logic [QW-1:0]                         quota,
    output logic [TW-1:0]                         wait_full_ms,
    output logic [TW-1:0]                         wait_desired_ms,
    output logic [TW-1:0]                         full_at_ms,
    output logic [TW-1:0]                         desired_at_ms
);

    localparam int PW = 2 * W;

    logic          enable_reg, enable_next;
    logic [QW-1:0] capacity_reg, capacity_next;
    logic [TW-1:0] interval_reg, interval_next;
    logic [QW-1:0] stored_reg, stored_next;
    logic [TW-1:0] last_time_reg, last_time_next;

    logic          command_reg;
    logic [TW-1:0] now_reg;
    logic [QW-1:0] amount_reg;
    logic [QW-1:0] desired_reg;
    logic [QW-1:0] refq_reg, refq_next;
    logic [QW-1:0] quota_reg, quota_next;
    logic [TW-1:0] wfull_reg, wfull_next;
    logic [TW-1:0] wdes_reg, wdes_next;

    logic [QW-1:0] quota_out_reg;
    logic [TW-1:0] wfull_out_reg;
    logic [TW-1:0] wdes_out_reg;
    logic [TW-1:0] full_at_reg;
    logic [TW-1:0] des_at_reg;

    logic [TW-1:0] elapsed;
    logic [QW-1:0] room;
    logic [QW-1:0] gap;
    logic [QW-1:0] after_sub;
    logic          consume;
    logic [W-1:0]  md_a, md_b, md_d;
    logic          md_done;
    logic [PW-1:0] md_q;

    prrl_muldiv #(
        .W(W)
    ) u_muldiv (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.md_start),
        .a    (md_a),
        .b    (md_b),
        .d    (md_d),
        .done (md_done),
        .q    (md_q)
    );

    assign consume   = (command_reg == prrl_pkg::CMD_CONSUME);
    assign elapsed   = now_reg - last_time_reg;
    assign room      = capacity_reg - stored_reg;
    assign gap       = (quota_reg < capacity_reg) ? capacity_reg - quota_reg : '0;
    assign after_sub = (amount_reg > refq_reg) ? '0 : refq_reg - amount_reg;

    always_comb
    begin
        case (cmd.md_sel)
            prrl_pkg::SEL_FULL:
            begin
                md_a = W'(interval_reg);
                md_b = W'(gap);
                md_d = W'(capacity_reg);
            end
            prrl_pkg::SEL_DES:
            begin
                md_a = W'(wfull_reg);
                md_b = W'(desired_reg);
                md_d = W'(capacity_reg);
            end
            default:
            begin
                md_a = W'(capacity_reg);
                md_b = W'(elapsed);
                md_d = W'(interval_reg);
            end
        endcase
    end

    always_comb
    begin
        enable_next   = enable_reg;
        capacity_next = capacity_reg;
        interval_next = interval_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                prrl_pkg::CFG_ENABLE:   enable_next   = cfg_data[0];
                prrl_pkg::CFG_CAPACITY: capacity_next = cfg_data[QW-1:0];
                prrl_pkg::CFG_INTERVAL: interval_next = cfg_data[TW-1:0];
                default:                enable_next   = enable_reg;
            endcase
        end
    end

    always_comb
    begin
        stored_next    = stored_reg;
        last_time_next = last_time_reg;
        refq_next      = refq_reg;
        quota_next     = quota_reg;
        wfull_next     = wfull_reg;
        wdes_next      = wdes_reg;
        if (cmd.set_disabled)
        begin
            quota_next = capacity_reg;
            wfull_next = '0;
            wdes_next  = '0;
        end
        if (cmd.set_bypass)
        begin
            refq_next = capacity_reg;
        end
        if (cmd.take_fill)
        begin
            refq_next = (md_q >= PW'(room)) ? capacity_reg : stored_reg + md_q[QW-1:0];
        end
        if (cmd.apply)
        begin
            quota_next = consume ? after_sub : refq_reg;
            wfull_next = '0;
            wdes_next  = '0;
            if (consume)
            begin
                stored_next    = after_sub;
                last_time_next = now_reg;
            end
        end
        if (cmd.take_full)
        begin
            wfull_next = md_q[TW-1:0];
        end
        if (cmd.take_des)
        begin
            wdes_next = (|md_q[PW-1:TW]) ? '1 : md_q[TW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= prrl_pkg::ENABLE_RESET;
            capacity_reg  <= QW'(prrl_pkg::CAPACITY_RESET);
            interval_reg  <= TW'(prrl_pkg::INTERVAL_RESET);
            stored_reg    <= QW'(prrl_pkg::CAPACITY_RESET);
            last_time_reg <= '0;
        end
        else
        begin
            enable_reg    <= enable_next;
            capacity_reg  <= capacity_next;
            interval_reg  <= interval_next;
            stored_reg    <= stored_next;
            last_time_reg <= last_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= command;
            now_reg     <= now_ms;
            amount_reg  <= amount;
            desired_reg <= desired_quota;
        end
        refq_reg  <= refq_next;
        quota_reg <= quota_next;
        wfull_reg <= wfull_next;
        wdes_reg  <= wdes_next;
        if (cmd.load_out)
        begin
            quota_out_reg <= quota_reg;
            wfull_out_reg <= wfull_reg;
            wdes_out_reg  <= wdes_reg;
            full_at_reg   <= now_reg + wfull_reg;
            des_at_reg    <= now_reg + wdes_reg;
        end
    end

    assign status.enable      = enable_reg;
    assign status.fill_bypass = (stored_reg >= capacity_reg) || (interval_reg == '0);
    assign status.cap_zero    = (capacity_reg == '0);
    assign status.md_done     = md_done;

    assign quota           = quota_out_reg;
    assign wait_full_ms    = wfull_out_reg;
    assign wait_desired_ms = wdes_out_reg;
    assign full_at_ms      = full_at_reg;
    assign desired_at_ms   = des_at_reg;

endmodule

`default_nettype wire

// ===== src/prrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// prrl_ctrl
// sequencer for refill, consume and the two wait computations
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module prrl_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire prrl_pkg::ctrl_status_t status,
    output prrl_pkg::ctrl_cmd_t         cmd
);

    prrl_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prrl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = prrl_pkg::S_CHECK;
                end
            end
            prrl_pkg::S_CHECK:
            begin
                if (!status.enable)
                begin
                    state_next = prrl_pkg::S_DONE;
                end
                else if (status.fill_bypass)
                begin
                    state_next = prrl_pkg::S_APPLY;
                end
                else
                begin
                    state_next = prrl_pkg::S_FILL_RUN;
                end
            end
            prrl_pkg::S_FILL_RUN:
            begin
                if (status.md_done)
                begin
                    state_next = prrl_pkg::S_APPLY;
                end
            end
            prrl_pkg::S_APPLY:
            begin
                state_next = status.cap_zero ? prrl_pkg::S_DONE : prrl_pkg::S_FULL_START;
            end
            prrl_pkg::S_FULL_START:
            begin
                state_next = prrl_pkg::S_FULL_RUN;
            end
            prrl_pkg::S_FULL_RUN:
            begin
                if (status.md_done)
                begin
                    state_next = prrl_pkg::S_DES_START;
                end
            end
            prrl_pkg::S_DES_START:
            begin
                state_next = prrl_pkg::S_DES_RUN;
            end
            prrl_pkg::S_DES_RUN:
            begin
                if (status.md_done)
                begin
                    state_next = prrl_pkg::S_DONE;
                end
            end
            prrl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = prrl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = prrl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.md_sel = prrl_pkg::SEL_FILL;
        unique case (state_reg)
            prrl_pkg::S_IDLE:
            begin
                cmd.capture = in_valid;
            end
            prrl_pkg::S_CHECK:
            begin
                cmd.set_disabled = !status.enable;
                cmd.set_bypass   = status.enable && status.fill_bypass;
                cmd.md_start     = status.enable && !status.fill_bypass;
            end
            prrl_pkg::S_FILL_RUN:
            begin
                cmd.take_fill = status.md_done;
            end
            prrl_pkg::S_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            prrl_pkg::S_FULL_START:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = prrl_pkg::SEL_FULL;
            end
            prrl_pkg::S_FULL_RUN:
            begin
                cmd.take_full = status.md_done;
                cmd.md_sel    = prrl_pkg::SEL_FULL;
            end
            prrl_pkg::S_DES_START:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = prrl_pkg::SEL_DES;
            end
            prrl_pkg::S_DES_RUN:
            begin
                cmd.take_des = status.md_done;
                cmd.md_sel   = prrl_pkg::SEL_DES;
            end
            prrl_pkg::S_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd.md_sel = prrl_pkg::SEL_FILL;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prrl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != prrl_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // a result is never written over one that is still waiting
    `AST_NEVER(a_no_overwrite, clk, rst_n, cmd.load_out && out_valid_reg && out_stall,
        "result register loaded while held")
    // an accepted transaction starts its refill check next cycle
    `AST_HOLDS(a_accept_check, clk, rst_n, (in_valid && !in_stall) |=> (state_reg == prrl_pkg::S_CHECK),
        "accepted transaction did not enter check")
    // a new result only follows the done state
    `AST_HOLDS(a_valid_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == prrl_pkg::S_DONE),
        "result raised outside done state")
    // the arithmetic unit finishes only while the sequencer waits for it
    `AST_HOLDS(a_done_in_run, clk, rst_n, status.md_done |-> (state_reg == prrl_pkg::S_FILL_RUN || state_reg == prrl_pkg::S_FULL_RUN || state_reg == prrl_pkg::S_DES_RUN),
        "arithmetic done seen outside a run state")

endmodule

`default_nettype wire
